[rtl/rcd_pkg.sv]
// Shared types, codes and constants for the record chunk deframer.
package rcd_pkg;

	localparam int DEF_INDEX_BYTES = 4;
	localparam int DEF_TICK_BYTES  = 8;
	localparam int DEF_TIME_BYTES  = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_INDEX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_END   = 2'd2;

	localparam logic [3:0] PH_MAGIC   = 4'd0;
	localparam logic [3:0] PH_VERSION = 4'd1;
	localparam logic [3:0] PH_INDEX   = 4'd2;
	localparam logic [3:0] PH_SNAPS   = 4'd3;
	localparam logic [3:0] PH_ACTS    = 4'd4;
	localparam logic [3:0] PH_START   = 4'd5;
	localparam logic [3:0] PH_END     = 4'd6;
	localparam logic [3:0] PH_KIND    = 4'd7;
	localparam logic [3:0] PH_FTICK   = 4'd8;
	localparam logic [3:0] PH_FTIME   = 4'd9;
	localparam logic [3:0] PH_FSIZE   = 4'd10;
	localparam logic [3:0] PH_PAYLOAD = 4'd11;
	localparam logic [3:0] PH_SKIP    = 4'd12;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_HEADER  = 2'd1;
	localparam logic [1:0] EV_PAYLOAD = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MAGIC     = 3'd1;
	localparam logic [2:0] ST_VERSION   = 3'd2;
	localparam logic [2:0] ST_METADATA  = 3'd3;
	localparam logic [2:0] ST_KIND      = 3'd4;
	localparam logic [2:0] ST_TRUNCATED = 3'd5;
	localparam logic [2:0] ST_COUNTS    = 3'd6;

	localparam logic [7:0] FORMAT_VERSION = 8'd1;
	localparam logic [7:0] KIND_SNAPSHOT  = 8'd0;
	localparam logic [7:0] KIND_ACTION    = 8'd1;
	localparam logic [3:0] MAGIC_LEN      = 4'd8;
	localparam logic [3:0] COUNT_LEN      = 4'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic        frame_kind;
		logic [63:0] frame_tick;
		logic [63:0] frame_time;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic        chunk_done;
		logic [2:0]  chunk_status;
	} out_word_t;

	// Magic "RCHNK001", first byte at index 0.
	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h52;
			3'd1: b = 8'h43;
			3'd2: b = 8'h48;
			3'd3: b = 8'h4E;
			3'd4: b = 8'h4B;
			3'd5: b = 8'h30;
			3'd6: b = 8'h30;
			3'd7: b = 8'h31;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[rtl/rcd_parser.sv]
// Parse state and per-byte next-state logic of the chunk deframer.
module rcd_parser #(
	parameter int INDEX_BYTES = rcd_pkg::DEF_INDEX_BYTES,
	parameter int TICK_BYTES  = rcd_pkg::DEF_TICK_BYTES,
	parameter int TIME_BYTES  = rcd_pkg::DEF_TIME_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  rcd_pkg::in_word_t in_data,
	input  logic [31:0]       expected_index,
	input  logic [63:0]       expected_start_tick,
	input  logic [63:0]       expected_end_tick,
	output rcd_pkg::out_word_t result
);

	localparam logic [3:0] IDX_LEN  = 4'(INDEX_BYTES);
	localparam logic [3:0] TICK_LEN = 4'(TICK_BYTES);
	localparam logic [3:0] TIME_LEN = 4'(TIME_BYTES);

	logic [3:0]  phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [63:0] shift_q, shift_d;
	logic [31:0] decl_snaps_q, decl_snaps_d;
	logic [31:0] decl_acts_q, decl_acts_d;
	logic [31:0] seen_snaps_q, seen_snaps_d;
	logic [31:0] seen_acts_q, seen_acts_d;
	logic        kind_q, kind_d;
	logic [63:0] tick_q, tick_d;
	logic [63:0] time_q, time_d;
	logic [31:0] left_q, left_d;
	logic [2:0]  err_q, err_d;

	logic [7:0]  b;
	logic [3:0]  cnt_inc;
	logic [63:0] gathered;
	logic [3:0]  glen;
	logic        gdone;
	logic [31:0] left_dec;

	assign b        = in_data.data_byte;
	assign cnt_inc  = cnt_q + 4'd1;
	assign gathered = shift_q | ({56'd0, b} << {cnt_q[2:0], 3'b000});
	assign gdone    = cnt_inc >= glen;
	assign left_dec = (left_q != 32'd0) ? left_q - 32'd1 : left_q;

	always_comb begin
		case (phase_q)
			rcd_pkg::PH_INDEX: glen = IDX_LEN;
			rcd_pkg::PH_SNAPS, rcd_pkg::PH_ACTS, rcd_pkg::PH_FSIZE: glen = rcd_pkg::COUNT_LEN;
			rcd_pkg::PH_FTIME: glen = TIME_LEN;
			default: glen = TICK_LEN;
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		shift_d      = shift_q;
		decl_snaps_d = decl_snaps_q;
		decl_acts_d  = decl_acts_q;
		seen_snaps_d = seen_snaps_q;
		seen_acts_d  = seen_acts_q;
		kind_d       = kind_q;
		tick_d       = tick_q;
		time_d       = time_q;
		left_d       = left_q;
		err_d        = err_q;
		result       = '0;

		// shared little-endian field gather
		if (phase_q >= rcd_pkg::PH_INDEX && phase_q <= rcd_pkg::PH_END ||
				phase_q >= rcd_pkg::PH_FTICK && phase_q <= rcd_pkg::PH_FSIZE) begin
			if (gdone) begin
				cnt_d   = 4'd0;
				shift_d = 64'd0;
			end else begin
				cnt_d   = cnt_inc;
				shift_d = gathered;
			end
		end

		case (phase_q)
			rcd_pkg::PH_MAGIC: begin
				if (b != rcd_pkg::magic_byte(cnt_q[2:0])) begin
					err_d   = rcd_pkg::ST_MAGIC;
					phase_d = rcd_pkg::PH_SKIP;
					cnt_d   = 4'd0;
					shift_d = 64'd0;
				end else if (cnt_inc >= rcd_pkg::MAGIC_LEN) begin
					cnt_d   = 4'd0;
					phase_d = rcd_pkg::PH_VERSION;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			rcd_pkg::PH_VERSION: begin
				if (b != rcd_pkg::FORMAT_VERSION) begin
					err_d   = rcd_pkg::ST_VERSION;
					phase_d = rcd_pkg::PH_SKIP;
				end else begin
					phase_d = rcd_pkg::PH_INDEX;
				end
			end
			rcd_pkg::PH_INDEX: begin
				if (gdone) begin
					if (gathered != {32'd0, expected_index}) begin
						err_d   = rcd_pkg::ST_METADATA;
						phase_d = rcd_pkg::PH_SKIP;
					end else begin
						phase_d = rcd_pkg::PH_SNAPS;
					end
				end
			end
			rcd_pkg::PH_SNAPS: begin
				if (gdone) begin
					decl_snaps_d = gathered[31:0];
					phase_d      = rcd_pkg::PH_ACTS;
				end
			end
			rcd_pkg::PH_ACTS: begin
				if (gdone) begin
					decl_acts_d = gathered[31:0];
					phase_d     = rcd_pkg::PH_START;
				end
			end
			rcd_pkg::PH_START: begin
				if (gdone) begin
					if (gathered != expected_start_tick) begin
						err_d   = rcd_pkg::ST_METADATA;
						phase_d = rcd_pkg::PH_SKIP;
					end else begin
						phase_d = rcd_pkg::PH_END;
					end
				end
			end
			rcd_pkg::PH_END: begin
				if (gdone) begin
					if (gathered != expected_end_tick) begin
						err_d   = rcd_pkg::ST_METADATA;
						phase_d = rcd_pkg::PH_SKIP;
					end else begin
						phase_d = rcd_pkg::PH_KIND;
					end
				end
			end
			rcd_pkg::PH_KIND: begin
				if (b == rcd_pkg::KIND_SNAPSHOT) begin
					kind_d       = 1'b0;
					seen_snaps_d = seen_snaps_q + 32'd1;
					phase_d      = rcd_pkg::PH_FTICK;
				end else if (b == rcd_pkg::KIND_ACTION) begin
					kind_d      = 1'b1;
					seen_acts_d = seen_acts_q + 32'd1;
					phase_d     = rcd_pkg::PH_FTICK;
				end else begin
					err_d   = rcd_pkg::ST_KIND;
					phase_d = rcd_pkg::PH_SKIP;
				end
			end
			rcd_pkg::PH_FTICK: begin
				if (gdone) begin
					tick_d  = gathered;
					phase_d = rcd_pkg::PH_FTIME;
				end
			end
			rcd_pkg::PH_FTIME: begin
				if (gdone) begin
					time_d  = gathered;
					phase_d = rcd_pkg::PH_FSIZE;
				end
			end
			rcd_pkg::PH_FSIZE: begin
				if (gdone) begin
					left_d           = gathered[31:0];
					result.event_res = rcd_pkg::EV_HEADER;
					phase_d = (gathered[31:0] == 32'd0) ? rcd_pkg::PH_KIND : rcd_pkg::PH_PAYLOAD;
				end
			end
			rcd_pkg::PH_PAYLOAD: begin
				result.event_res    = rcd_pkg::EV_PAYLOAD;
				result.payload_byte = b;
				left_d              = left_dec;
				if (left_dec == 32'd0) begin
					result.payload_last = 1'b1;
					phase_d             = rcd_pkg::PH_KIND;
				end
			end
			default: begin
			end
		endcase

		// first error wins
		if (err_q != rcd_pkg::ST_OK) begin
			err_d = err_q;
		end

		result.frame_kind = kind_d;
		result.frame_tick = tick_d;
		result.frame_time = time_d;
		result.chunk_done = in_data.chunk_end;

		if (in_data.chunk_end) begin
			if (err_d != rcd_pkg::ST_OK) begin
				result.chunk_status = err_d;
			end else if (phase_d != rcd_pkg::PH_KIND) begin
				result.chunk_status = rcd_pkg::ST_TRUNCATED;
			end else if (seen_snaps_d != decl_snaps_d || seen_acts_d != decl_acts_d) begin
				result.chunk_status = rcd_pkg::ST_COUNTS;
			end else begin
				result.chunk_status = rcd_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= rcd_pkg::PH_MAGIC;
			cnt_q        <= '0;
			shift_q      <= '0;
			decl_snaps_q <= '0;
			decl_acts_q  <= '0;
			seen_snaps_q <= '0;
			seen_acts_q  <= '0;
			kind_q       <= 1'b0;
			tick_q       <= '0;
			time_q       <= '0;
			left_q       <= '0;
			err_q        <= rcd_pkg::ST_OK;
		end else if (load) begin
			if (in_data.chunk_end) begin
				phase_q      <= rcd_pkg::PH_MAGIC;
				cnt_q        <= '0;
				shift_q      <= '0;
				decl_snaps_q <= '0;
				decl_acts_q  <= '0;
				seen_snaps_q <= '0;
				seen_acts_q  <= '0;
				kind_q       <= 1'b0;
				tick_q       <= '0;
				time_q       <= '0;
				left_q       <= '0;
				err_q        <= rcd_pkg::ST_OK;
			end else begin
				phase_q      <= phase_d;
				cnt_q        <= cnt_d;
				shift_q      <= shift_d;
				decl_snaps_q <= decl_snaps_d;
				decl_acts_q  <= decl_acts_d;
				seen_snaps_q <= seen_snaps_d;
				seen_acts_q  <= seen_acts_d;
				kind_q       <= kind_d;
				tick_q       <= tick_d;
				time_q       <= time_d;
				left_q       <= left_d;
				err_q        <= err_d;
			end
		end
	end

endmodule

[rtl/rcd_out_reg.sv]
// Output result register with valid/stall handshake.
module rcd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  rcd_pkg::out_word_t result,
	output logic               full_stalled,
	output logic               out_valid,
	input  logic               out_stall,
	output rcd_pkg::out_word_t out_data
);

	logic               valid_q;
	rcd_pkg::out_word_t data_q;

	// register can take a new word when empty or draining this cycle
	assign full_stalled = valid_q & out_stall;
	assign out_valid    = valid_q;
	assign out_data     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

[rtl/record_chunk_deframer.sv]
// Top level of the record chunk deframer: config registers, parser and output register.
//
// Takes one chunk byte per word on the input channel and returns exactly one result word
// per byte on the next cycle, at a sustained rate of one byte per clock. The parse state is
// updated in the cycle a byte is accepted, and the result lands in a single output register;
// a new byte is taken whenever that register is empty or being drained, so the only thing
// that slows the block is stall on the output. The chunk must open with the magic "RCHNK001"
// and version byte 1, then a little-endian header (index, snapshot count, action count,
// start tick, end tick) whose index and ticks are checked against the configuration.
// Frames follow: kind byte, tick, timestamp, 4-byte payload size and payload. A frame
// header word (event 1) is issued on the last size byte, each payload byte as event 2.
// The word carrying chunk_end also carries chunk_done and the chunk status: the first
// error seen, else truncated if the chunk did not stop at a frame boundary, else a count
// mismatch, else OK. After that word all parse state returns to its reset value. The user
// must write configuration only while no byte is in flight; the block does not enforce it.
module record_chunk_deframer #(
	parameter int INDEX_BYTES = rcd_pkg::DEF_INDEX_BYTES,
	parameter int TICK_BYTES  = rcd_pkg::DEF_TICK_BYTES,
	parameter int TIME_BYTES  = rcd_pkg::DEF_TIME_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input byte channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rcd_pkg::in_word_t              in_data,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output rcd_pkg::out_word_t             out_data,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic               accept;
	logic               full_stalled;
	rcd_pkg::out_word_t result;

	logic [31:0] exp_index_q;
	logic [63:0] exp_start_q;
	logic [63:0] exp_end_q;

	// stall only while a finished word is still waiting downstream
	assign in_stall = full_stalled;
	assign accept   = in_valid & ~full_stalled;

	// configuration registers; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_index_q <= '0;
			exp_start_q <= '0;
			exp_end_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rcd_pkg::CFG_EXPECTED_INDEX: exp_index_q <= cfg_data[31:0];
				rcd_pkg::CFG_EXPECTED_START: exp_start_q <= cfg_data;
				rcd_pkg::CFG_EXPECTED_END:   exp_end_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rcd_parser #(
		.INDEX_BYTES(INDEX_BYTES),
		.TICK_BYTES (TICK_BYTES),
		.TIME_BYTES (TIME_BYTES)
	) u_parser (
		.clk                (clk),
		.arst_n             (arst_n),
		.load               (accept),
		.in_data            (in_data),
		.expected_index     (exp_index_q),
		.expected_start_tick(exp_start_q),
		.expected_end_tick  (exp_end_q),
		.result             (result)
	);

	rcd_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.result      (result),
		.full_stalled(full_stalled),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule
